// ===== rtl/bmbrm_pkg.sv =====
`timescale 1ns / 1ps

package bmbrm_pkg;

    // Field and register widths
    localparam int unsigned DIM_W    = 7;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned WADDR_W  = 14;
    localparam int unsigned COORD_W  = 6;
    localparam int unsigned STATUS_W = 2;

    // Default frame limits
    localparam int unsigned DEF_MAX_WIDTH  = 64;
    localparam int unsigned DEF_MAX_HEIGHT = 64;

    // Register reset values and counter limit
    localparam logic [DIM_W-1:0]   RESET_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0]   RESET_HEIGHT = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 13'd8191;

    // Configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_END   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SIZE_ERR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        SIDE_LEFT,
        SIDE_TOP,
        SIDE_RIGHT
    } side_t;

endpackage

// ===== rtl/binary_mask_border_run_midpoint.sv =====
`timescale 1ns / 1ps
// Load: one pixel transaction per cycle while idle; the mask goes into a 1-bit RAM.
// Frame end: a size error goes via the finish state to the output register.
// Otherwise the border walk visits up to 2*H+W pixels (RAM read, then compare and
// address step through one shared adder), and its result takes the same path.
// The block takes no pixel from the last pixel until the result is registered.
// Reset: pixel count cleared, frame size 64 x 64, mask RAM left uninitialized.
module binary_mask_border_run_midpoint #(
    parameter int unsigned MAX_WIDTH  = bmbrm_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bmbrm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [bmbrm_pkg::DIM_W-1:0]    cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_pixel,
    input  logic                           s_frame_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bmbrm_pkg::STATUS_W-1:0] m_status,
    output logic [bmbrm_pkg::COORD_W-1:0]  m_mid_x,
    output logic [bmbrm_pkg::COORD_W-1:0]  m_mid_y
);

    localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned DIM_W       = bmbrm_pkg::DIM_W;
    localparam int unsigned COUNT_W     = bmbrm_pkg::COUNT_W;
    localparam int unsigned WADDR_W     = bmbrm_pkg::WADDR_W;
    localparam int unsigned COORD_W     = bmbrm_pkg::COORD_W;
    localparam int unsigned STATUS_W    = bmbrm_pkg::STATUS_W;

    // Mask RAM
    logic mask_mem [STORE_DEPTH];
    logic rd_bit_reg;

    // Configuration
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;

    // Control and walk state
    bmbrm_pkg::state_t state_reg, state_next;
    bmbrm_pkg::side_t  side_reg, side_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [WADDR_W-1:0] walk_addr_reg, walk_addr_next;
    logic [DIM_W-1:0]   cur_x_reg, cur_x_next;
    logic [DIM_W-1:0]   cur_y_reg, cur_y_next;
    logic [DIM_W-1:0]   px_reg, px_next;
    logic [DIM_W-1:0]   py_reg, py_next;
    logic [DIM_W-1:0]   sx_reg, sx_next;
    logic [DIM_W-1:0]   sy_reg, sy_next;
    logic               started_reg, started_next;

    // Pending result and output register
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [COORD_W-1:0]  res_x_reg, res_x_next;
    logic [COORD_W-1:0]  res_y_reg, res_y_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [COORD_W-1:0]  m_mid_x_reg, m_mid_x_next;
    logic [COORD_W-1:0]  m_mid_y_reg, m_mid_y_next;

    // Datapath
    logic               s_accept;
    logic               store_en;
    logic [COUNT_W-1:0] count_inc;
    logic [WADDR_W-1:0] frame_area;
    logic               size_ok;
    logic               count_ok;
    logic [WADDR_W-1:0] step_operand;
    logic [WADDR_W-1:0] walk_sum;
    logic [DIM_W:0]     sum_x;
    logic [DIM_W:0]     sum_y;

    assign s_ready  = (state_reg == bmbrm_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign store_en = (32'(count_reg) < 32'(STORE_DEPTH));
    assign count_inc = (count_reg == bmbrm_pkg::COUNT_MAX) ? count_reg
                                                           : count_reg + COUNT_W'(1);
    assign frame_area = WADDR_W'(frame_width_reg) * WADDR_W'(frame_height_reg);
    assign size_ok = (frame_width_reg != '0) && (frame_height_reg != '0) &&
                     (32'(frame_width_reg) <= 32'(MAX_WIDTH)) &&
                     (32'(frame_height_reg) <= 32'(MAX_HEIGHT));
    assign count_ok = (WADDR_W'(count_inc) == frame_area);

    // Shared address stepper: up a column, along the row, or down a column
    always_comb begin
        case (side_reg)
            bmbrm_pkg::SIDE_LEFT: step_operand = WADDR_W'(0) - WADDR_W'(frame_width_reg);
            bmbrm_pkg::SIDE_TOP:  step_operand = WADDR_W'(1);
            default:              step_operand = WADDR_W'(frame_width_reg);
        endcase
    end
    assign walk_sum = walk_addr_reg + step_operand;

    // Midpoint of start and the previously visited pixel
    assign sum_x = {1'b0, sx_reg} + {1'b0, px_reg};
    assign sum_y = {1'b0, sy_reg} + {1'b0, py_reg};

    // Write pixels, read one border pixel per walk step
    always_ff @(posedge aclk) begin
        if (s_accept && store_en) begin
            mask_mem[ADDR_W'(count_reg)] <= s_pixel;
        end
        if (state_reg == bmbrm_pkg::ST_READ) begin
            rd_bit_reg <= mask_mem[ADDR_W'(walk_addr_reg)];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= bmbrm_pkg::RESET_WIDTH;
            frame_height_reg <= bmbrm_pkg::RESET_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bmbrm_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data;
                bmbrm_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bmbrm_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            started_reg <= started_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        side_reg       <= side_next;
        walk_addr_reg  <= walk_addr_next;
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        res_status_reg <= res_status_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        m_status_reg   <= m_status_next;
        m_mid_x_reg    <= m_mid_x_next;
        m_mid_y_reg    <= m_mid_y_next;
    end

    // Sequencer: load, walk the border, hand off the result
    always_comb begin
        state_next      = state_reg;
        side_next       = side_reg;
        count_next      = count_reg;
        walk_addr_next  = walk_addr_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        started_next    = started_reg;
        res_status_next = res_status_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_mid_x_next    = m_mid_x_reg;
        m_mid_y_next    = m_mid_y_reg;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            bmbrm_pkg::ST_IDLE: begin
                if (s_accept) begin
                    count_next = count_inc;
                    if (s_frame_last) begin
                        count_next = '0;
                        if (size_ok && count_ok) begin
                            // Start at the bottom of the left column
                            side_next      = bmbrm_pkg::SIDE_LEFT;
                            walk_addr_next = WADDR_W'(count_inc) - WADDR_W'(frame_width_reg);
                            cur_x_next     = '0;
                            cur_y_next     = frame_height_reg - DIM_W'(1);
                            started_next   = 1'b0;
                            state_next     = bmbrm_pkg::ST_READ;
                        end else begin
                            res_status_next = bmbrm_pkg::STATUS_SIZE_ERR;
                            res_x_next      = '0;
                            res_y_next      = '0;
                            state_next      = bmbrm_pkg::ST_FINISH;
                        end
                    end
                end
            end

            bmbrm_pkg::ST_READ: begin
                state_next = bmbrm_pkg::ST_EVAL;
            end

            bmbrm_pkg::ST_EVAL: begin
                px_next = cur_x_reg;
                py_next = cur_y_reg;
                if (started_reg && !rd_bit_reg) begin
                    // Run ended at the previous pixel
                    res_status_next = bmbrm_pkg::STATUS_FOUND;
                    res_x_next      = sum_x[COORD_W:1];
                    res_y_next      = sum_y[COORD_W:1];
                    state_next      = bmbrm_pkg::ST_FINISH;
                end else begin
                    if (!started_reg && rd_bit_reg) begin
                        started_next = 1'b1;
                        sx_next      = cur_x_reg;
                        sy_next      = cur_y_reg;
                    end
                    state_next = bmbrm_pkg::ST_READ;
                    // Advance along the border
                    case (side_reg)
                        bmbrm_pkg::SIDE_LEFT: begin
                            if (cur_y_reg == '0) begin
                                side_next = bmbrm_pkg::SIDE_TOP;
                            end else begin
                                cur_y_next     = cur_y_reg - DIM_W'(1);
                                walk_addr_next = walk_sum;
                            end
                        end
                        bmbrm_pkg::SIDE_TOP: begin
                            if (cur_x_reg == frame_width_reg - DIM_W'(1)) begin
                                side_next = bmbrm_pkg::SIDE_RIGHT;
                            end else begin
                                cur_x_next     = cur_x_reg + DIM_W'(1);
                                walk_addr_next = walk_sum;
                            end
                        end
                        default: begin
                            if (cur_y_reg == frame_height_reg - DIM_W'(1)) begin
                                res_status_next = bmbrm_pkg::STATUS_NO_END;
                                res_x_next      = '0;
                                res_y_next      = '0;
                                state_next      = bmbrm_pkg::ST_FINISH;
                            end else begin
                                cur_y_next     = cur_y_reg + DIM_W'(1);
                                walk_addr_next = walk_sum;
                            end
                        end
                    endcase
                end
            end

            bmbrm_pkg::ST_FINISH: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_mid_x_next  = res_x_reg;
                    m_mid_y_next  = res_y_reg;
                    state_next    = bmbrm_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bmbrm_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_mid_x  = m_mid_x_reg;
    assign m_mid_y  = m_mid_y_reg;

    // A frame end stops intake in the cycle after it is accepted
    a_frame_end_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_frame_last) |=> !s_ready)
        else $error("input accepted right after a frame end");

    // A frame end clears the pixel count
    a_count_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_frame_last) |=> (count_reg == '0))
        else $error("pixel count not cleared at frame end");

    // Coordinates are zero unless a midpoint was found
    a_zero_coords: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != bmbrm_pkg::STATUS_FOUND)) |->
        ((m_mid_x == '0) && (m_mid_y == '0)))
        else $error("nonzero coordinates without a midpoint");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned DIM_W         = bmbrm_pkg::DIM_W;
    localparam int unsigned COORD_W       = bmbrm_pkg::COORD_W;
    localparam int unsigned STATUS_W      = bmbrm_pkg::STATUS_W;
    localparam int unsigned MASK_DEPTH    = bmbrm_pkg::DEF_MAX_WIDTH *
                                            bmbrm_pkg::DEF_MAX_HEIGHT;
    localparam int unsigned RANDOM_PIXELS = 1100;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES  = 2 * (2 * bmbrm_pkg::DEF_MAX_HEIGHT +
                                            bmbrm_pkg::DEF_MAX_WIDTH) + 16;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned LIMIT_CYCLES  = 1_000_000;

    typedef enum int unsigned {
        PAT_CLEAR,
        PAT_SOLID,
        PAT_NOISE,
        PAT_BLOCK
    } pattern_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COORD_W-1:0]  mid_x;
        logic [COORD_W-1:0]  mid_y;
    } midpoint_t;

    // Mirror of the mask store, pixel counter and frame size; queue of pending midpoints
    class midpoint_scoreboard;
        bit          mask_bits[MASK_DEPTH];
        int unsigned pixels_seen;
        int unsigned width_reg;
        int unsigned height_reg;
        midpoint_t   expected_midpoints[$];
        int unsigned failures;
        int unsigned status_tally[3];

        function new();
            pixels_seen = 0;
            width_reg   = bmbrm_pkg::RESET_WIDTH;
            height_reg  = bmbrm_pkg::RESET_HEIGHT;
            failures    = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function void set_register(logic index, int unsigned value);
            if (index == bmbrm_pkg::REG_FRAME_WIDTH) begin
                width_reg = value & 32'h7f;
            end else begin
                height_reg = value & 32'h7f;
            end
        endfunction

        // Walk left column upward, top row rightward, right column downward
        function midpoint_t walk_border();
            midpoint_t   found;
            bit          started;
            bit          ended;
            bit          here;
            int unsigned start_x, start_y, end_x, end_y, prev_x, prev_y;
            int unsigned x, y, step;
            started = 1'b0;
            ended   = 1'b0;
            start_x = 0;
            start_y = 0;
            end_x   = 0;
            end_y   = 0;
            prev_x  = 0;
            prev_y  = 0;
            for (step = 0; step < 2 * height_reg + width_reg && !ended; step++) begin
                if (step < height_reg) begin
                    x = 0;
                    y = height_reg - 1 - step;
                end else if (step < height_reg + width_reg) begin
                    x = step - height_reg;
                    y = 0;
                end else begin
                    x = width_reg - 1;
                    y = step - height_reg - width_reg;
                end
                here = mask_bits[y * width_reg + x];
                if (!started) begin
                    if (here) begin
                        started = 1'b1;
                        start_x = x;
                        start_y = y;
                    end
                end else if (!here) begin
                    // end of run is the previously visited pixel
                    ended = 1'b1;
                    end_x = prev_x;
                    end_y = prev_y;
                end
                prev_x = x;
                prev_y = y;
            end
            if (ended) begin
                found.status = bmbrm_pkg::STATUS_FOUND;
                found.mid_x  = COORD_W'((start_x + end_x) >> 1);
                found.mid_y  = COORD_W'((start_y + end_y) >> 1);
            end else begin
                found.status = bmbrm_pkg::STATUS_NO_END;
                found.mid_x  = '0;
                found.mid_y  = '0;
            end
            return found;
        endfunction

        // Store the pixel; on the frame's last pixel predict its result
        function void note_pixel(logic pix, logic last);
            midpoint_t outcome;
            if (pixels_seen < MASK_DEPTH) mask_bits[pixels_seen] = pix;
            if (pixels_seen < bmbrm_pkg::COUNT_MAX) pixels_seen++;
            if (!last) return;
            if (width_reg < 1 || width_reg > bmbrm_pkg::DEF_MAX_WIDTH ||
                height_reg < 1 || height_reg > bmbrm_pkg::DEF_MAX_HEIGHT ||
                pixels_seen != width_reg * height_reg) begin
                outcome.status = bmbrm_pkg::STATUS_SIZE_ERR;
                outcome.mid_x  = '0;
                outcome.mid_y  = '0;
            end else begin
                outcome = walk_border();
            end
            pixels_seen = 0;
            status_tally[outcome.status]++;
            expected_midpoints.push_back(outcome);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [COORD_W-1:0] mid_x,
                                   logic [COORD_W-1:0] mid_y);
            midpoint_t want;
            if (expected_midpoints.size() == 0) begin
                $error("result with no frame pending: status %0d mid_x %0d mid_y %0d",
                       status, mid_x, mid_y);
                failures++;
                return;
            end
            want = expected_midpoints.pop_front();
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                failures++;
            end
            if (mid_x !== want.mid_x) begin
                $error("mid_x mismatch: expected %0d, actual %0d", want.mid_x, mid_x);
                failures++;
            end
            if (mid_y !== want.mid_y) begin
                $error("mid_y mismatch: expected %0d, actual %0d", want.mid_y, mid_y);
                failures++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic                cfg_index;
    logic [DIM_W-1:0]    cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic                s_pixel;
    logic                s_frame_last;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [COORD_W-1:0]  m_mid_x;
    logic [COORD_W-1:0]  m_mid_y;

    logic        idling_on;
    logic        hold_off_request;
    int unsigned cycle_count;
    int unsigned pixels_sent;
    int unsigned frames_sent;
    int unsigned size_changes;
    int unsigned frame_width_now;
    int unsigned frame_height_now;

    midpoint_scoreboard board = new();

    binary_mask_border_run_midpoint dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .s_frame_last (s_frame_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_mid_x      (m_mid_x),
        .m_mid_y      (m_mid_y)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Offer one pixel, optionally after an idle burst, and hold it until the transaction
    task automatic send_pixel(input logic pix, input logic last);
        int unsigned gap;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pixel      <= pix;
        s_frame_last <= last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_pixel(pix, last);
        pixels_sent++;
    endtask

    // Drop valid and wait until every pending midpoint has come back
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (board.expected_midpoints.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame_size(input int unsigned w, input int unsigned h);
        wait_for_drain();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= bmbrm_pkg::REG_FRAME_WIDTH;
        cfg_wr_data <= DIM_W'(w);
        @(posedge aclk);
        board.set_register(bmbrm_pkg::REG_FRAME_WIDTH, w);
        cfg_index   <= bmbrm_pkg::REG_FRAME_HEIGHT;
        cfg_wr_data <= DIM_W'(h);
        @(posedge aclk);
        board.set_register(bmbrm_pkg::REG_FRAME_HEIGHT, h);
        cfg_wr_en        <= 1'b0;
        frame_width_now  = w;
        frame_height_now = h;
        size_changes++;
    endtask

    // Stream one frame; the block pattern sets pixels inside the given rectangle
    task automatic send_frame(input int unsigned n_pixels, input pattern_t pattern,
                              input int unsigned x_lo, input int unsigned x_hi,
                              input int unsigned y_lo, input int unsigned y_hi,
                              input bit invert);
        int unsigned i, x, y;
        logic        pix;
        for (i = 0; i < n_pixels; i++) begin
            x = (frame_width_now != 0) ? i % frame_width_now : 0;
            y = (frame_width_now != 0) ? i / frame_width_now : 0;
            case (pattern)
                PAT_CLEAR: pix = 1'b0;
                PAT_SOLID: pix = 1'b1;
                PAT_NOISE: pix = ($urandom_range(0, 3) != 0);
                default:   pix = (x >= x_lo && x <= x_hi && y >= y_lo && y <= y_hi);
            endcase
            send_pixel(pix ^ invert, i == n_pixels - 1);
        end
        frames_sent++;
    endtask

    // Mostly well-formed frames with random content, a few with a wrong length
    task automatic send_random_frame();
        int unsigned area, n_pixels, pick;
        int unsigned x_lo, x_hi, y_lo, y_hi, x_top, y_top;
        pattern_t    pattern;
        area     = frame_width_now * frame_height_now;
        n_pixels = area;
        pick     = $urandom_range(0, 13);
        if (pick == 0) begin
            n_pixels = area + $urandom_range(1, 3);
        end else if (pick == 1 && area > 1) begin
            n_pixels = $urandom_range(1, area - 1);
        end
        if (n_pixels == 0) n_pixels = $urandom_range(1, 6);
        x_top = (frame_width_now != 0) ? frame_width_now - 1 : 0;
        y_top = (frame_height_now != 0) ? frame_height_now - 1 : 0;
        x_lo  = $urandom_range(0, x_top);
        x_hi  = $urandom_range(x_lo, x_top);
        y_lo  = $urandom_range(0, y_top);
        y_hi  = $urandom_range(y_lo, y_top);
        case ($urandom_range(0, 7))
            0:       pattern = PAT_CLEAR;
            1:       pattern = PAT_SOLID;
            2, 3:    pattern = PAT_NOISE;
            default: pattern = PAT_BLOCK;
        endcase
        send_frame(n_pixels, pattern, x_lo, x_hi, y_lo, y_hi, $urandom_range(0, 1));
    endtask

    // Result side: check each transaction, stall in bursts, honor the long hold-off
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
                board.check_result(m_status, m_mid_x, m_mid_y);
            end
            if (hold_off_request === 1'b1) begin
                hold_off_request <= 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && idling_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 8);
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL binary_mask_border_run_midpoint");
        $finish;
    end

    initial begin : stimulus
        int unsigned w, h, phase, frames, rand_start;
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_pixel          <= 1'b0;
        s_frame_last     <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= bmbrm_pkg::REG_FRAME_WIDTH;
        cfg_wr_data      <= '0;
        idling_on        <= 1'b1;
        hold_off_request <= 1'b0;
        pixels_sent      = 0;
        frames_sent      = 0;
        size_changes     = 0;
        frame_width_now  = bmbrm_pkg::RESET_WIDTH;
        frame_height_now = bmbrm_pkg::RESET_HEIGHT;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset size: a short frame against the 64 x 64 default is a count error
        send_frame(16, PAT_BLOCK, 0, 9, 0, 4, 1'b0);

        // Small frame: empty, solid border, run of the single bottom-left pixel
        set_frame_size(3, 2);
        send_frame(6, PAT_CLEAR, 0, 0, 0, 0, 1'b0);
        send_frame(6, PAT_SOLID, 0, 0, 0, 0, 1'b0);
        send_frame(6, PAT_BLOCK, 0, 0, 1, 1, 1'b0);
        // Count mismatch: short and long frames
        send_frame(5, PAT_SOLID, 0, 0, 0, 0, 1'b0);
        send_frame(7, PAT_NOISE, 0, 0, 0, 0, 1'b0);

        // Single pixel frame, set and clear
        set_frame_size(1, 1);
        send_frame(1, PAT_SOLID, 0, 0, 0, 0, 1'b0);
        send_frame(1, PAT_CLEAR, 0, 0, 0, 0, 1'b0);

        // Out-of-range sizes, with pixel counts matching the product where possible
        set_frame_size(0, 5);
        send_frame(1, PAT_SOLID, 0, 0, 0, 0, 1'b0);
        set_frame_size(65, 1);
        send_frame(65, PAT_SOLID, 0, 0, 0, 0, 1'b0);
        set_frame_size(1, 127);
        send_frame(127, PAT_SOLID, 0, 0, 0, 0, 1'b0);

        // Widest single row, run starting at the bottom-left pixel
        set_frame_size(bmbrm_pkg::DEF_MAX_WIDTH, 1);
        send_frame(bmbrm_pkg::DEF_MAX_WIDTH, PAT_BLOCK, 10, 20, 0, 0, 1'b1);

        // Tallest narrow frame, run up the left column to the top-left corner
        set_frame_size(2, bmbrm_pkg::DEF_MAX_HEIGHT);
        send_frame(2 * bmbrm_pkg::DEF_MAX_HEIGHT, PAT_BLOCK, 0, 0, 0, 40, 1'b0);

        // Random phases, one frame size each; phase 0 runs under a long result hold-off
        phase      = 0;
        rand_start = pixels_sent;
        while (pixels_sent - rand_start < RANDOM_PIXELS) begin
            if (phase == 0) begin
                w = 2;
                h = 2;
            end else begin
                case ($urandom_range(0, 19))
                    0: begin
                        if ($urandom_range(0, 1) == 0) begin
                            w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(65, 127);
                            h = $urandom_range(1, 4);
                        end else begin
                            w = $urandom_range(1, 4);
                            h = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(65, 127);
                        end
                    end
                    1: begin
                        w = bmbrm_pkg::DEF_MAX_WIDTH;
                        h = $urandom_range(1, 3);
                    end
                    2: begin
                        w = $urandom_range(1, 3);
                        h = bmbrm_pkg::DEF_MAX_HEIGHT;
                    end
                    3, 4, 5: begin
                        w = $urandom_range(1, 16);
                        h = $urandom_range(1, 16);
                    end
                    default: begin
                        w = $urandom_range(1, 6);
                        h = $urandom_range(1, 6);
                    end
                endcase
            end
            set_frame_size(w, h);
            if (phase == 0) hold_off_request <= 1'b1;
            frames = (phase == 0) ? 16 : $urandom_range(3, 8);
            repeat (frames) begin
                if (pixels_sent - rand_start < RANDOM_PIXELS) send_random_frame();
                // quiet tail: no idling on either side
                if (pixels_sent - rand_start > RANDOM_PIXELS / 2) idling_on <= 1'b0;
            end
            phase++;
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.expected_midpoints.size() != 0) begin
            $error("%0d frame results never arrived", board.expected_midpoints.size());
        end
        $display("Covered %0d frames in %0d pixel transactions: %0d midpoints, %0d without end,",
                 frames_sent, pixels_sent, board.status_tally[bmbrm_pkg::STATUS_FOUND],
                 board.status_tally[bmbrm_pkg::STATUS_NO_END]);
        $display("%0d size errors, over %0d frame-size settings incl. out-of-range and 64 edges.",
                 board.status_tally[bmbrm_pkg::STATUS_SIZE_ERR], size_changes);
        if (board.failures == 0 && board.expected_midpoints.size() == 0) begin
            $display("PASS binary_mask_border_run_midpoint");
        end else begin
            $display("FAIL binary_mask_border_run_midpoint");
        end
        $finish;
    end

endmodule
